// File: rtl/core/wtgl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wtgl_pkg;

    localparam logic [7:0] C_END_BYTE    = 8'h00;
    localparam logic [7:0] C_NEWLINE     = 8'h0A;
    localparam logic [7:0] C_ASCII_LO    = 8'h20;
    localparam logic [7:0] C_ASCII_END   = 8'h7F;
    localparam logic [7:0] C_LEAD_LO     = 8'hA1;
    localparam logic [7:0] C_LEAD_HI     = 8'hF7;
    localparam logic [7:0] C_SYM_LEAD_LO = 8'hA1;
    localparam logic [7:0] C_SYM_LEAD_END = 8'hAA;
    localparam logic [7:0] C_L1_LEAD_LO  = 8'hB0;
    localparam logic [7:0] C_L1_LEAD_HI  = 8'hF7;
    localparam logic [7:0] C_LOW_BASE    = 8'hA1;
    localparam logic [15:0] C_ROW_LEN    = 16'd94;

    localparam int C_GB_W     = 11;
    localparam int C_CMD_DEPTH = 4;
    localparam int C_RES_DEPTH = 4;

    localparam logic [2:0] REG_FONT_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FONT_HEIGHT = 3'd1;
    localparam logic [2:0] REG_AREA_WIDTH  = 3'd2;
    localparam logic [2:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [2:0] REG_TOP_OFFSET  = 3'd4;
    localparam logic [2:0] REG_ASCII_BASE  = 3'd5;
    localparam logic [2:0] REG_SYMBOL_BASE = 3'd6;
    localparam logic [2:0] REG_LEVEL1_BASE = 3'd7;

    typedef enum logic [1:0] {
        OP_END     = 2'd0,
        OP_NEWLINE = 2'd1,
        OP_GLYPH   = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] hi;
        logic [7:0] lo;
        logic       wide;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  font_width;
        logic [6:0]  font_height;
        logic [11:0] area_width;
        logic [11:0] area_height;
        logic [11:0] top_offset;
        logic [15:0] ascii_base;
        logic [15:0] symbol_base;
        logic [15:0] level1_base;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic [11:0]        x_pos;
        logic signed [15:0] y_pos;
        logic [6:0]         glyph_width;
        logic [15:0]        glyph_index;
        logic [15:0]        line_count;
    } t_place;

    typedef struct packed {
        t_place      place;
        logic [23:0] rom_address;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/wtgl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module wtgl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] C_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == C_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wtgl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wtgl_front
    import wtgl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_cmd_full,
    output logic            o_cmd_push,
    output t_cmd            o_cmd
);

    logic       r_lead_pending, n_lead_pending;
    logic [7:0] r_lead_byte, n_lead_byte;
    logic       accept;

    assign accept = i_push && !i_cmd_full;

    always_comb begin
        n_lead_pending = r_lead_pending;
        n_lead_byte    = r_lead_byte;
        o_cmd_push     = 1'b0;
        o_cmd.op       = OP_GLYPH;
        o_cmd.hi       = 8'h00;
        o_cmd.lo       = i_text_byte;
        o_cmd.wide     = 1'b0;
        if (accept) begin
            if (i_text_byte == C_END_BYTE) begin
                o_cmd_push     = 1'b1;
                o_cmd.op       = OP_END;
                n_lead_pending = 1'b0;
                n_lead_byte    = 8'h00;
            end else if (r_lead_pending) begin
                o_cmd_push     = 1'b1;
                o_cmd.hi       = r_lead_byte;
                o_cmd.wide     = 1'b1;
                n_lead_pending = 1'b0;
            end else if (i_text_byte == C_NEWLINE) begin
                o_cmd_push = 1'b1;
                o_cmd.op   = OP_NEWLINE;
            end else if (i_text_byte >= C_ASCII_LO && i_text_byte < C_ASCII_END) begin
                o_cmd_push = 1'b1;
            end else if (i_text_byte >= C_LEAD_LO && i_text_byte <= C_LEAD_HI) begin
                n_lead_pending = 1'b1;
                n_lead_byte    = i_text_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_lead_byte    <= 8'h00;
        end else begin
            r_lead_pending <= n_lead_pending;
            r_lead_byte    <= n_lead_byte;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wtgl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wtgl_back
    import wtgl_pkg::*;
#(
    parameter int ROM_ADDR_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_load_y,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_result   o_res
);

    localparam int PW = 16 + C_GB_W;

    logic [11:0]        r_x, n_x;
    logic [15:0]        r_y, n_y;
    logic [15:0]        r_lines, n_lines;
    logic [C_GB_W-1:0]  r_glyph_bytes;
    logic               r_a_valid, n_a_valid;
    t_place             r_a, n_a;
    logic               r_b_valid;
    t_result            r_b;

    logic        a_ready, b_ready;
    logic [4:0]  rows;
    logic [6:0]  w;
    logic [12:0] x_sum;
    logic        wrap;
    logic [16:0] y_inc;
    logic [15:0] y_nl, l_nl;
    logic [11:0] x0;
    logic [15:0] y0, l0;
    logic [17:0] bottom;
    logic        shown;
    logic [7:0]  row;
    logic [15:0] base, t_lin, idx;
    logic [PW-1:0] product, addr_mask;

    assign rows = (i_cfg.font_height == 7'd0) ? 5'd1
                : {1'b0, 4'((i_cfg.font_height - 7'd1) >> 3)} + 5'd1;

    always_ff @(posedge i_clk) begin
        r_glyph_bytes <= C_GB_W'(rows) * C_GB_W'(i_cfg.font_width);
    end

    assign b_ready   = !r_b_valid || !i_res_full;
    assign a_ready   = !r_a_valid || b_ready;
    assign o_cmd_pop = i_cmd_valid && a_ready;

    // cursor advance
    always_comb begin
        w      = i_cmd.wide ? {i_cfg.font_width, 1'b0} : {1'b0, i_cfg.font_width};
        x_sum  = {1'b0, r_x} + {6'b0, w};
        wrap   = x_sum > {1'b0, i_cfg.area_width};
        y_inc  = {r_y[15], r_y} + {10'b0, i_cfg.font_height};
        y_nl   = (!y_inc[16] && y_inc[15]) ? 16'h7FFF : y_inc[15:0];
        l_nl   = (r_lines == 16'hFFFF) ? r_lines : r_lines + 16'd1;
        x0     = wrap ? 12'd0 : r_x;
        y0     = wrap ? y_nl : r_y;
        l0     = wrap ? l_nl : r_lines;
        bottom = {{2{y0[15]}}, y0} + {11'b0, i_cfg.font_height} - 18'd1;
        shown  = !bottom[17] && ($signed({y0[15], y0}) < $signed({5'b0, i_cfg.area_height}));
    end

    // font table index
    always_comb begin
        row  = 8'h00;
        base = i_cfg.symbol_base;
        if (i_cmd.hi >= C_SYM_LEAD_LO && i_cmd.hi < C_SYM_LEAD_END) begin
            row = i_cmd.hi - C_SYM_LEAD_LO;
        end else if (i_cmd.hi >= C_L1_LEAD_LO && i_cmd.hi <= C_L1_LEAD_HI) begin
            row  = i_cmd.hi - C_L1_LEAD_LO;
            base = i_cfg.level1_base;
        end
        t_lin = {8'b0, row} * C_ROW_LEN + {8'b0, i_cmd.lo} - {8'b0, C_LOW_BASE};
        if (i_cmd.hi == 8'h00) begin
            idx = {8'b0, i_cmd.lo} + i_cfg.ascii_base;
        end else if ((i_cmd.hi >= C_SYM_LEAD_LO && i_cmd.hi < C_SYM_LEAD_END)
                     || (i_cmd.hi >= C_L1_LEAD_LO && i_cmd.hi <= C_L1_LEAD_HI)) begin
            idx = {t_lin[14:0], 1'b0} + base;
        end else begin
            idx = i_cfg.symbol_base;
        end
    end

    always_comb begin
        n_x             = r_x;
        n_y             = r_y;
        n_lines         = r_lines;
        n_a_valid       = 1'b0;
        n_a.kind        = 1'b0;
        n_a.x_pos       = x0;
        n_a.y_pos       = y0;
        n_a.glyph_width = w;
        n_a.glyph_index = idx;
        n_a.line_count  = l0;
        if (o_cmd_pop) begin
            case (i_cmd.op)
                OP_END: begin
                    n_a_valid       = 1'b1;
                    n_a.kind        = 1'b1;
                    n_a.x_pos       = 12'd0;
                    n_a.y_pos       = 16'sd0;
                    n_a.glyph_width = 7'd0;
                    n_a.glyph_index = 16'd0;
                    n_a.line_count  = r_lines;
                    n_x             = 12'd0;
                    n_y             = {{4{i_cfg.top_offset[11]}}, i_cfg.top_offset};
                    n_lines         = 16'd1;
                end
                OP_NEWLINE: begin
                    if (r_x != 12'd0) begin
                        n_x     = 12'd0;
                        n_y     = y_nl;
                        n_lines = l_nl;
                    end
                end
                OP_GLYPH: begin
                    n_a_valid = shown;
                    n_x       = x0 + {5'b0, w};
                    n_y       = y0;
                    n_lines   = l0;
                end
                default: begin
                    n_a_valid = 1'b0;
                end
            endcase
        end
        if (i_load_y) begin
            n_y = {{4{i_cfg.top_offset[11]}}, i_cfg.top_offset};
        end
    end

    for (genvar gi = 0; gi < PW; gi++) begin : g_mask
        assign addr_mask[gi] = (gi < ROM_ADDR_BITS);
    end

    assign product = (PW'(r_a.glyph_index) * PW'(r_glyph_bytes)) & addr_mask;

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a <= n_a;
        end
        if (b_ready) begin
            r_b.place       <= r_a;
            r_b.rom_address <= product[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= 12'd0;
            r_y       <= 16'd0;
            r_lines   <= 16'd1;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_lines <= n_lines;
            if (a_ready) begin
                r_a_valid <= n_a_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    assign o_res_push = r_b_valid && !i_res_full;
    assign o_res      = r_b;

endmodule

`default_nettype wire

// File: rtl/core/wrapped_text_glyph_layout.sv
`timescale 1ns / 1ps
`default_nettype none

// Lays out a byte stream of ASCII and two-byte GB2312 text into wrapped lines and
// emits one result per visible glyph (position, width, font index, ROM address) and
// a line-count summary on byte 0, which also returns the cursor to its start. One
// text byte is taken per clock while the command queue is not full; a GB2312 glyph
// takes two bytes. A result passes through the command queue, the cursor stage (the
// only serial loop, one command a cycle while the result path is not stalled), the
// ROM address multiply stage and the result queue before it reaches the result ports.
// Configuration is written over the APB port at byte address 4*i while no text is
// in flight; writing top_offset also reloads the cursor row in the next cycle.

module wrapped_text_glyph_layout
    import wtgl_pkg::*;
#(
    parameter int ROM_ADDR_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_text_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_kind,
    output logic [11:0]      o_x_pos,
    output logic signed [15:0] o_y_pos,
    output logic [6:0]       o_glyph_width,
    output logic [15:0]      o_glyph_index,
    output logic [23:0]      o_rom_address,
    output logic [15:0]      o_line_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg    r_cfg;
    logic    cfg_wr, load_y;
    logic    r_load_y;
    t_cmd    front_cmd, q_cmd;
    logic    front_push, cmd_full, cmd_empty, cmd_pop;
    t_result back_res, q_res;
    logic    res_push, res_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign load_y = cfg_wr && (paddr[4:2] == REG_TOP_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.font_width  <= 6'd8;
            r_cfg.font_height <= 7'd16;
            r_cfg.area_width  <= 12'd128;
            r_cfg.area_height <= 12'd64;
            r_cfg.top_offset  <= 12'd0;
            r_cfg.ascii_base  <= 16'd0;
            r_cfg.symbol_base <= 16'd0;
            r_cfg.level1_base <= 16'd0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_FONT_WIDTH:  r_cfg.font_width  <= pwdata[5:0];
                REG_FONT_HEIGHT: r_cfg.font_height <= pwdata[6:0];
                REG_AREA_WIDTH:  r_cfg.area_width  <= pwdata[11:0];
                REG_AREA_HEIGHT: r_cfg.area_height <= pwdata[11:0];
                REG_TOP_OFFSET:  r_cfg.top_offset  <= pwdata[11:0];
                REG_ASCII_BASE:  r_cfg.ascii_base  <= pwdata[15:0];
                REG_SYMBOL_BASE: r_cfg.symbol_base <= pwdata[15:0];
                REG_LEVEL1_BASE: r_cfg.level1_base <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // load the cursor row once the new top_offset is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_y <= 1'b0;
        end else begin
            r_load_y <= load_y;
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_FONT_WIDTH:  prdata = {26'd0, r_cfg.font_width};
            REG_FONT_HEIGHT: prdata = {25'd0, r_cfg.font_height};
            REG_AREA_WIDTH:  prdata = {20'd0, r_cfg.area_width};
            REG_AREA_HEIGHT: prdata = {20'd0, r_cfg.area_height};
            REG_TOP_OFFSET:  prdata = {20'd0, r_cfg.top_offset};
            REG_ASCII_BASE:  prdata = {16'd0, r_cfg.ascii_base};
            REG_SYMBOL_BASE: prdata = {16'd0, r_cfg.symbol_base};
            REG_LEVEL1_BASE: prdata = {16'd0, r_cfg.level1_base};
            default:         prdata = 32'd0;
        endcase
    end

    wtgl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_text_byte (i_text_byte),
        .i_cmd_full  (cmd_full),
        .o_cmd_push  (front_push),
        .o_cmd       (front_cmd)
    );

    assign full = cmd_full;

    wtgl_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (C_CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (q_cmd)
    );

    wtgl_back #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_load_y    (r_load_y),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    wtgl_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (C_RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_res)
    );

    assign o_kind        = q_res.place.kind;
    assign o_x_pos       = q_res.place.x_pos;
    assign o_y_pos       = q_res.place.y_pos;
    assign o_glyph_width = q_res.place.glyph_width;
    assign o_glyph_index = q_res.place.glyph_index;
    assign o_line_count  = q_res.place.line_count;
    assign o_rom_address = q_res.rom_address;

endmodule

`default_nettype wire
